>>> design/fsc_pkg.sv
// Package for the frame segmenter: codes, header constants, the command and
// status structs between controller and datapath, and the CRC-16 byte update.
// No dependencies.
package fsc_pkg;

  localparam int unsigned MtuW = 16;
  localparam int unsigned LenW = 16;
  localparam int unsigned IdW = 32;
  localparam int unsigned CrcW = 16;
  localparam int unsigned HdrBytes = 14;
  localparam int unsigned HdrCntW = 4;
  localparam int unsigned DivCntW = 4;
  localparam int unsigned PaddrW = 3;

  localparam logic [MtuW-1:0] MtuReset = 16'd255;
  localparam logic [MtuW-1:0] MtuMin = 16'd15;
  localparam logic [MtuW-1:0] HdrLen = 16'd14;
  localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [7:0] HdrMagic = 8'hE5;
  localparam logic [7:0] HdrVersion = 8'h01;

  // Input item function codes.
  localparam logic FuncStart = 1'b0;
  localparam logic FuncByte = 1'b1;

  // Register index taken from the word address bit of paddr.
  localparam logic RegMtu = 1'b0;

  typedef struct packed {
    logic start;     // load a new message, begin the frame-count division
    logic div_step;  // one restoring division step
    logic fix;       // settle frame total and first chunk size
    logic hdr_step;  // fold one header byte into the CRC
    logic fold;      // fold one payload byte
    logic emit;      // this payload byte closes the chunk
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;   // the offered start item has zero length
    logic div_last;   // final division step
    logic hdr_last;   // final header byte
    logic chunk_end;  // the next payload byte closes the chunk
    logic last;       // the chunk that closes now is the final frame
    logic out_full;   // the descriptor register is occupied
  } dp_sts_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                input logic [7:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/fsc_if.sv
// Channel interfaces of the frame segmenter: the input item channel and the
// frame descriptor channel. Depends on fsc_pkg for field widths.
interface fsc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [fsc_pkg::IdW-1:0]     message_id;
  logic [fsc_pkg::LenW-1:0]    message_length;
  logic [7:0]                  data_byte;

  modport source (output valid, func, message_id, message_length, data_byte,
                  input ready);
  modport sink (input valid, func, message_id, message_length, data_byte,
                output ready);
endinterface

interface fsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [fsc_pkg::IdW-1:0]     frame_message_id;
  logic [fsc_pkg::LenW-1:0]    frame_index;
  logic [fsc_pkg::LenW-1:0]    frame_total;
  logic [fsc_pkg::LenW-1:0]    chunk_length;
  logic [fsc_pkg::CrcW-1:0]    frame_crc;
  logic                        last_frame;

  modport source (output valid, frame_message_id, frame_index, frame_total,
                  chunk_length, frame_crc, last_frame, input ready);
  modport sink (input valid, frame_message_id, frame_index, frame_total,
                chunk_length, frame_crc, last_frame, output ready);
endinterface

>>> design/frame_segmenter_crc16.sv
// Top level of the frame segmenter: APB register, controller, datapath.
// Depends on fsc_pkg, fsc_if.sv, fsc_ctrl and fsc_dp.
//
//   Channel   Role    Moves per transaction
//   in_i      sink    one start item (id, length) or one payload byte
//   out_o     source  one frame descriptor (header fields and CRC-16)
//   APB       slave   write or read of the mtu register at address 0
//
// Payload bytes are taken one per cycle while the input is not stalled. A start item
// with nonzero length keeps the input stalled while the bit-serial frame-count divider
// runs, the total and chunk size settle, and the header CRC is built (one header byte
// per cycle through the CRC unit). After a descriptor that is not the last one, the
// input stalls again while the next chunk's header is folded. While the next byte
// would close a chunk and the descriptor register is full and not being read, every
// item waits. rst_ni clears the controller, descriptor valid and mtu (255).
module frame_segmenter_crc16 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fsc_in_if.sink                        in_i,
  fsc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fsc_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [fsc_pkg::MtuW-1:0] mtu_q;
  fsc_pkg::dp_cmd_t         cmd;
  fsc_pkg::dp_sts_t         sts;
  logic                     in_fire;

  // The register is selected by the word address bit; one register exists.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fsc_pkg::RegMtu) ? {16'h0000, mtu_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= fsc_pkg::MtuReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == fsc_pkg::RegMtu)) begin
      mtu_q <= pwdata[fsc_pkg::MtuW-1:0];
    end
  end

  // The controller owns the input handshake; the datapath owns the output.
  fsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mtu_i            (mtu_q),
    .message_id_i     (in_i.message_id),
    .message_length_i (in_i.message_length),
    .data_byte_i      (in_i.data_byte),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_o            (out_o)
  );

  assign in_fire = in_i.valid && in_i.ready;

  // A start item with nonzero length makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.func == fsc_pkg::FuncStart) && (in_i.message_length != '0)
    |=> !in_i.ready)
    else $error("input not stalled after a message start");

  // A descriptor that is not the last one is followed by a header fold.
  a_hdr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && !sts.last |=> !in_i.ready)
    else $error("input not stalled during header CRC");

  // A shown descriptor always has an index below the frame total.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, out_o.frame_index} < {1'b0, out_o.frame_total}))
    else $error("frame index not below frame total");

  // The descriptor carrying the final index is flagged as the last frame.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (({1'b0, out_o.frame_index} + 17'd1) == {1'b0, out_o.frame_total})
    |-> out_o.last_frame)
    else $error("final frame not flagged as last");

endmodule

>>> design/fsc_ctrl.sv
// Controller of the frame segmenter: sequences division, header CRC and
// payload folding. Depends on fsc_pkg for the command and status structs.
module fsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_func_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  input  fsc_pkg::dp_sts_t  sts_i,
  output fsc_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StFix,
    StHdr,
    StRun
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   is_start;

  // Ready only in idle and run; in run, stall only when the byte would close a chunk
  // and the descriptor slot cannot take a new descriptor in the same cycle.
  assign in_ready_o = (state_q == StIdle) ||
                      ((state_q == StRun) &&
                       (!sts_i.chunk_end || !sts_i.out_full || out_ready_i));
  assign accept   = in_valid_i && in_ready_o;
  assign is_start = (in_func_i == fsc_pkg::FuncStart);

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = accept && is_start && !sts_i.len_zero;
    cmd_o.fold     = accept && !is_start && (state_q == StRun);
    cmd_o.emit     = cmd_o.fold && sts_i.chunk_end;
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.fix      = (state_q == StFix);
    cmd_o.hdr_step = (state_q == StHdr);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle, StRun: begin
        if (accept && is_start) begin
          state_d = sts_i.len_zero ? StIdle : StDiv;
        end else if (cmd_o.emit) begin
          state_d = sts_i.last ? StIdle : StHdr;
        end
      end
      StDiv: begin
        if (sts_i.div_last) state_d = StFix;
      end
      StFix: state_d = StHdr;
      StHdr: begin
        if (sts_i.hdr_last) state_d = StRun;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/fsc_dp.sv
// Datapath of the frame segmenter: message registers, serial divider,
// header byte selection, CRC register and the descriptor output register.
// Depends on fsc_pkg and the fsc_out_if interface.
module fsc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [fsc_pkg::MtuW-1:0]    mtu_i,
  input  logic [fsc_pkg::IdW-1:0]     message_id_i,
  input  logic [fsc_pkg::LenW-1:0]    message_length_i,
  input  logic [7:0]                  data_byte_i,
  input  fsc_pkg::dp_cmd_t            cmd_i,
  output fsc_pkg::dp_sts_t            sts_o,
  fsc_out_if.source                   out_o
);

  localparam int unsigned LW = fsc_pkg::LenW;

  logic [fsc_pkg::IdW-1:0]      id_q;
  logic [LW-1:0]                rem_q, total_q, idx_q, chunk_q, bic_q;
  logic [fsc_pkg::CrcW-1:0]     crc_q;
  logic [LW-1:0]                divisor_q, quo_q, acc_q;
  logic [fsc_pkg::DivCntW-1:0]  div_cnt_q;
  logic [fsc_pkg::HdrCntW-1:0]  hdr_cnt_q;

  logic                         out_valid_q;
  logic [fsc_pkg::IdW-1:0]      o_id_q;
  logic [LW-1:0]                o_idx_q, o_total_q, o_chunk_q;
  logic [fsc_pkg::CrcW-1:0]     o_crc_q;
  logic                         o_last_q;

  logic [fsc_pkg::MtuW-1:0]     mtu_eff;
  logic [LW-1:0]                maxp;
  logic [LW:0]                  acc_sh;
  logic                         acc_ge;
  logic [8*fsc_pkg::HdrBytes-1:0] hdr_vec;
  logic [7:0]                   hdr_byte;
  logic [fsc_pkg::CrcW-1:0]     crc_pay;
  logic [LW-1:0]                rem_dec;
  logic [LW:0]                  idx_inc;

  assign mtu_eff = (mtu_i < fsc_pkg::MtuMin) ? fsc_pkg::MtuMin : mtu_i;
  assign maxp    = mtu_eff - fsc_pkg::HdrLen;

  // Restoring division, one quotient bit per step.
  assign acc_sh = {acc_q, quo_q[LW-1]};
  assign acc_ge = (acc_sh >= {1'b0, divisor_q});

  // Header bytes, first byte in the top position; the count runs down.
  assign hdr_vec  = {fsc_pkg::HdrMagic, fsc_pkg::HdrVersion, id_q, idx_q,
                     total_q, chunk_q, 16'h0000};
  assign hdr_byte = hdr_vec[{hdr_cnt_q, 3'b000} +: 8];

  assign crc_pay = fsc_pkg::crc_byte(crc_q, data_byte_i);
  assign rem_dec = rem_q - 1'b1;
  assign idx_inc = {1'b0, idx_q} + 1'b1;

  assign sts_o.len_zero  = (message_length_i == '0);
  assign sts_o.div_last  = (div_cnt_q == '0);
  assign sts_o.hdr_last  = (hdr_cnt_q == '0);
  assign sts_o.chunk_end = ({1'b0, bic_q} + 1'b1 >= {1'b0, chunk_q});
  assign sts_o.last      = (idx_inc >= {1'b0, total_q}) || (rem_dec == '0);
  assign sts_o.out_full  = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      id_q      <= message_id_i;
      rem_q     <= message_length_i;
      idx_q     <= '0;
      bic_q     <= '0;
      divisor_q <= maxp;
      quo_q     <= message_length_i;
      acc_q     <= '0;
      div_cnt_q <= fsc_pkg::DivCntW'(LW - 1);
    end
    if (cmd_i.div_step) begin
      acc_q     <= acc_ge ? LW'(acc_sh - {1'b0, divisor_q}) : acc_sh[LW-1:0];
      quo_q     <= {quo_q[LW-2:0], acc_ge};
      div_cnt_q <= div_cnt_q - 1'b1;
    end
    if (cmd_i.fix) begin
      total_q   <= quo_q + LW'(acc_q != '0);
      chunk_q   <= (rem_q < divisor_q) ? rem_q : divisor_q;
      crc_q     <= fsc_pkg::CrcInit;
      hdr_cnt_q <= fsc_pkg::HdrCntW'(fsc_pkg::HdrBytes - 1);
    end
    if (cmd_i.hdr_step) begin
      crc_q     <= fsc_pkg::crc_byte(crc_q, hdr_byte);
      hdr_cnt_q <= hdr_cnt_q - 1'b1;
    end
    if (cmd_i.fold) begin
      rem_q <= rem_dec;
      // A chunk that closes and is followed by another restarts the CRC.
      if (cmd_i.emit && !sts_o.last) begin
        crc_q <= fsc_pkg::CrcInit;
        bic_q <= '0;
      end else begin
        crc_q <= crc_pay;
        bic_q <= bic_q + 1'b1;
      end
    end
    if (cmd_i.emit) begin
      o_id_q    <= id_q;
      o_idx_q   <= idx_q;
      o_total_q <= total_q;
      o_chunk_q <= chunk_q;
      o_crc_q   <= crc_pay;
      o_last_q  <= sts_o.last;
      if (!sts_o.last) begin
        idx_q     <= idx_inc[LW-1:0];
        chunk_q   <= (rem_dec < chunk_q) ? rem_dec : chunk_q;
        hdr_cnt_q <= fsc_pkg::HdrCntW'(fsc_pkg::HdrBytes - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.frame_message_id = o_id_q;
  assign out_o.frame_index      = o_idx_q;
  assign out_o.frame_total      = o_total_q;
  assign out_o.chunk_length     = o_chunk_q;
  assign out_o.frame_crc        = o_crc_q;
  assign out_o.last_frame       = o_last_q;

endmodule

>>> test/tb.sv
// Self-checking testbench for frame_segmenter_crc16: directed rows, then random messages.
// A local predictor supplies the expected frame descriptors.
// Depends on fsc_pkg, the channel interfaces in fsc_if.sv, and the block itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsc_pkg::*;

  // After a start item the block holds its input while it divides and folds the header,
  // and again for the header of each following chunk. This quiet time covers both.
  localparam int QuietCycles = 40;
  localparam int DrainLimit  = 20000;
  localparam int PhaseItems  = 85;
  localparam int Phases      = 6;

  // Kinds of directed row. A mtu row carries the new register value in its len field.
  typedef enum logic {RowItem, RowSetMtu} row_kind_e;

  // One stimulus row. When pin is set, the frame fields of the result are typed
  // into the row. Only the id and the CRC then come from the predictor.
  typedef struct packed {
    row_kind_e   kind;
    logic        func;
    logic [31:0] id;
    logic [15:0] len;
    logic [7:0]  data;
    logic        pin;
    logic [15:0] idx;
    logic [15:0] tot;
    logic [15:0] chunk;
    logic        last;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] frame_no;
    logic [15:0] total;
    logic [15:0] chunk;
    logic [15:0] crc;
    logic        last;
  } frame_desc_t;

  // Directed part. It covers stray bytes while idle and an empty message. It also covers
  // single-byte frames at mtu 15 and at an mtu below 15, and a message abandoned by a
  // new start. The mtu is changed twice in the middle of a message. The id, length, data
  // and mtu values include their extremes.
  localparam stim_row_t DirRows [25] = '{
    '{RowItem,   FuncByte,  0,            0,     'hFF, 0, 0, 0, 0, 0},
    '{RowItem,   FuncStart, 0,            0,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncStart, 'hFFFF_FFFF,  1,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'hA5, 1, 0, 1, 1, 1},
    '{RowSetMtu, FuncStart, 0,            15,    'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncStart, 'h1234_5678,  3,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h00, 1, 0, 3, 1, 0},
    '{RowItem,   FuncByte,  0,            0,     'hFF, 1, 1, 3, 1, 0},
    '{RowItem,   FuncByte,  0,            0,     'h5A, 1, 2, 3, 1, 1},
    '{RowSetMtu, FuncStart, 0,            0,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncStart, 'h8000_0001,  2,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h01, 1, 0, 2, 1, 0},
    '{RowItem,   FuncStart, 'hDEAD_BEEF,  5,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h80, 1, 0, 5, 1, 0},
    '{RowSetMtu, FuncStart, 0,            17,    'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h7F, 1, 1, 5, 1, 0},
    '{RowItem,   FuncStart, 'h0000_FFFF,  7,     'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h3C, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'hC3, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h99, 1, 0, 3, 3, 0},
    '{RowSetMtu, FuncStart, 0,            65535, 'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncStart, 'h5A5A_5A5A,  65535, 'h00, 0, 0, 0, 0, 0},
    '{RowItem,   FuncByte,  0,            0,     'h66, 0, 0, 0, 0, 0},
    '{RowItem,   FuncStart, 0,            0,     'h00, 0, 0, 0, 0, 0}
  };

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fsc_in_if  in_if ();
  fsc_out_if out_if ();

  frame_segmenter_crc16 dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state. It mirrors the segmenter: the configured mtu and the
  // message in progress.
  logic [15:0] cfg_mtu;
  logic        seg_active;
  logic [31:0] seg_id;
  logic [15:0] seg_left;
  logic [15:0] seg_total;
  logic [15:0] seg_index;
  logic [15:0] seg_chunk;
  logic [15:0] seg_fill;
  logic [15:0] seg_crc;

  frame_desc_t frames_due[$];
  int          mismatch_count;
  int          live_items;
  bit          src_calm;
  int          sink_hold_cycles;
  int          sink_stall_left;
  int          sink_calm_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net. The slowest correct run takes well under a tenth of this time.
  initial begin
    #(10ms);
    $display("TEST FAILED");
    $finish;
  end

  // CRC-16 with polynomial 0x1021. The byte is shifted in MSB first, and each bit's
  // feedback is the top CRC bit xor the data bit.
  function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  // Starts a chunk. The 14 header bytes are folded into a fresh CRC, with the CRC field
  // of the header taken as zero.
  function automatic void open_chunk();
    logic [111:0] hdr;
    logic [15:0]  c;
    hdr = {HdrMagic, HdrVersion, seg_id, seg_index, seg_total, seg_chunk, 16'h0000};
    c = CrcInit;
    for (int i = 0; i < HdrBytes; i++) begin
      c = crc16_fold(c, hdr[111 - 8*i -: 8]);
    end
    seg_crc  = c;
    seg_fill = '0;
  endfunction

  // Advances the predictor by one accepted input transaction. It returns 1 when that
  // transaction closes a chunk, and d then holds the descriptor the block must emit.
  function automatic bit next_descriptor(input stim_row_t r, output frame_desc_t d);
    int unsigned eff_mtu;
    int unsigned max_payload;
    logic        last;
    d = '0;
    if (r.func == FuncStart) begin
      // A start always replaces any message in progress. That message is dropped
      // without a descriptor.
      eff_mtu     = (cfg_mtu < MtuMin) ? MtuMin : cfg_mtu;
      max_payload = eff_mtu - HdrBytes;
      seg_id      = r.id;
      seg_left    = r.len;
      seg_index   = '0;
      if (r.len == 0) begin
        seg_active = 1'b0;
        seg_total  = '0;
        seg_chunk  = '0;
        seg_fill   = '0;
        seg_crc    = CrcInit;
        return 1'b0;
      end
      seg_total  = 16'((r.len + max_payload - 1) / max_payload);
      seg_chunk  = (r.len < max_payload) ? r.len : 16'(max_payload);
      seg_active = 1'b1;
      open_chunk();
      return 1'b0;
    end
    if (!seg_active) begin
      return 1'b0;
    end
    seg_crc  = crc16_fold(seg_crc, r.data);
    seg_fill = seg_fill + 16'd1;
    seg_left = seg_left - 16'd1;
    if (seg_fill < seg_chunk) begin
      return 1'b0;
    end
    last = (seg_index + 1 >= seg_total) || (seg_left == 0);
    d = '{seg_id, seg_index, seg_total, seg_chunk, seg_crc, last};
    if (last) begin
      seg_active = 1'b0;
    end else begin
      seg_index = seg_index + 16'd1;
      if (seg_left < seg_chunk) begin
        seg_chunk = seg_left;
      end
      open_chunk();
    end
    return 1'b1;
  endfunction

  // Idle length for either side. Most gaps are short and a few are long. A calm side
  // never idles.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic string desc_str(input frame_desc_t d);
    return $sformatf("id=%h idx=%0d tot=%0d len=%0d crc=%h last=%0b",
                     d.id, d.frame_no, d.total, d.chunk, d.crc, d.last);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Builds a random item. The fields that this function does not use get random values
  // too, so every input bit toggles.
  function automatic stim_row_t rand_row(input logic func, input logic [15:0] len);
    stim_row_t r;
    r       = '0;
    r.kind  = RowItem;
    r.func  = func;
    r.id    = $urandom;
    r.len   = (func == FuncStart) ? len : 16'($urandom_range(0, 65535));
    r.data  = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Offers an item on the input channel. It is called in the time step of a clock edge,
  // after that edge, so valid gets exactly one nonblocking update in that step. When
  // there is no gap, valid stays high and the payload moves on to the next item.
  task automatic push_item(input stim_row_t r);
    frame_desc_t d;
    int          gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.func           <= r.func;
    in_if.message_id     <= r.id;
    in_if.message_length <= r.len;
    in_if.data_byte      <= r.data;
    do @(posedge clk); while (!in_if.ready);
    // The transaction happened at this edge. Bytes that arrive outside a message are
    // ignored by the block, so they do not count as live stimulus.
    if (r.func == FuncStart || seg_active) begin
      live_items++;
    end
    if (next_descriptor(r, d)) begin
      if (r.pin) begin
        d.frame_no = r.idx;
        d.total    = r.tot;
        d.chunk    = r.chunk;
        d.last     = r.last;
      end
      frames_due.insert(frames_due.size(), d);
    end
  endtask

  // One APB transfer to the mtu register: a setup phase, then an access phase that
  // lasts until pready is high, then the bus returns to idle.
  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {RegMtu, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_mtu_readback();
    logic [31:0] rd;
    apb_xfer(1'b0, 32'h0, rd);
    if (rd !== {16'h0000, cfg_mtu}) begin
      report_mismatch($sformatf("mtu readback: expected %h, got %h", cfg_mtu, rd));
    end
  endtask

  // Stops the input, waits for every expected descriptor, and then waits until a start
  // or a header that is still being processed has time to finish.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic write_mtu(input logic [15:0] value);
    logic [31:0] rd;
    settle();
    apb_xfer(1'b1, {16'h0000, value}, rd);
    cfg_mtu = value;
    check_mtu_readback();
  endtask

  function automatic logic [15:0] pick_mtu();
    case ($urandom_range(7))
      0:       return 16'($urandom_range(0, 14));
      1:       return MtuMin;
      2:       return 16'd16;
      3:       return 16'($urandom_range(17, 40));
      4:       return 16'($urandom_range(41, 300));
      5:       return MtuReset;
      6:       return 16'hFFFF;
      default: return 16'($urandom_range(15, 65535));
    endcase
  endfunction

  // Most messages are well formed: a start and exactly its length in bytes. Some are
  // cut short and then abandoned by the next start. Some have huge lengths and get only
  // a few bytes. Some are empty, and a few are followed by stray bytes.
  task automatic send_random_message();
    int unsigned max_payload;
    int unsigned len;
    int unsigned sent;
    int          pick;
    max_payload = ((cfg_mtu < MtuMin) ? MtuMin : cfg_mtu) - HdrBytes;
    pick = $urandom_range(99);
    if (pick < 5) begin
      len = 0;
    end else if (pick < 20 && max_payload <= 20) begin
      // Exact multiples of the chunk size end on a chunk boundary.
      len = max_payload * $urandom_range(1, 3);
    end else if (pick >= 20 && pick < 25) begin
      len = $urandom_range(0, 65535);
    end else begin
      len = $urandom_range(1, 40);
    end
    sent = len;
    if (pick >= 20 && pick < 25) begin
      sent = (len < 5) ? len : $urandom_range(0, 5);
    end else if (len > 0 && $urandom_range(9) == 0) begin
      sent = $urandom_range(0, len - 1);
    end
    push_item(rand_row(FuncStart, 16'(len)));
    repeat (sent) push_item(rand_row(FuncByte, 16'h0));
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) push_item(rand_row(FuncByte, 16'h0));
    end
  endtask

  // Receiver. It stalls at random and sometimes runs calm for a stretch. When asked,
  // it holds off for a long time so that the descriptor register fills and the input
  // stalls.
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        sink_hold_cycles--;
      end else if (sink_stall_left > 0) begin
        out_if.ready <= 1'b0;
        sink_stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (sink_calm_left > 0) begin
          sink_calm_left--;
        end else if ($urandom_range(99) == 0) begin
          sink_calm_left = 150;
        end else if ($urandom_range(2) == 0) begin
          sink_stall_left = pick_gap(1'b0);
        end
      end
    end
  end

  // Checker. Each output transaction is compared with the oldest expected descriptor.
  always @(posedge clk) begin : frame_check
    frame_desc_t seen;
    frame_desc_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen = '{out_if.frame_message_id, out_if.frame_index, out_if.frame_total,
               out_if.chunk_length, out_if.frame_crc, out_if.last_frame};
      if (frames_due.size() == 0) begin
        report_mismatch({"unexpected descriptor: ", desc_str(seen)});
      end else begin
        want = frames_due.pop_front();
        if (seen !== want) begin
          report_mismatch({"descriptor mismatch: expected ", desc_str(want),
                           " got ", desc_str(seen)});
        end
      end
    end
  end

  initial begin
    // Every input is at a known value from time zero, and the predictor starts from
    // its reset state.
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_if.valid          <= 1'b0;
    in_if.func           <= FuncStart;
    in_if.message_id     <= '0;
    in_if.message_length <= '0;
    in_if.data_byte      <= '0;
    cfg_mtu    = MtuReset;
    seg_active = 1'b0;
    seg_id     = '0;
    seg_left   = '0;
    seg_total  = '0;
    seg_index  = '0;
    seg_chunk  = '0;
    seg_fill   = '0;
    seg_crc    = CrcInit;
    mismatch_count = 0;
    live_items     = 0;
    src_calm       = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_mtu_readback();

    // Directed rows. A mtu change first waits for every expected descriptor and the quiet time.
    foreach (DirRows[i]) begin
      if (DirRows[i].kind == RowSetMtu) begin
        write_mtu(DirRows[i].len);
      end else begin
        push_item(DirRows[i]);
      end
    end

    // Random phases, each with its own mtu. The first phase uses one byte per frame and
    // a long receiver hold-off, so the block backs up onto its input. One phase runs
    // with no sender gaps.
    for (int phase = 0; phase < Phases; phase++) begin
      int target;
      write_mtu((phase == 0) ? MtuMin : pick_mtu());
      src_calm = (phase == 3);
      if (phase == 0) begin
        sink_hold_cycles = 400;
      end
      target = live_items + PhaseItems;
      while (live_items < target) begin
        send_random_message();
      end
    end

    // Drain the remaining descriptors, then give the block time to emit anything it
    // should not.
    in_if.valid <= 1'b0;
    for (int n = 0; n < DrainLimit && frames_due.size() != 0; n++) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
    if (frames_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected descriptors never arrived, oldest %s",
                                frames_due.size(), desc_str(frames_due[0])));
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fsc_pkg.sv
design/fsc_if.sv
design/fsc_ctrl.sv
design/fsc_dp.sv
design/frame_segmenter_crc16.sv
test/tb.sv
